[sv/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg: shared definitions for the recursive median filter
// Sizes, register codes, sequencer states and the rank unit control bundle.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned MAX_WINDOW  = 31;
  localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int unsigned HALF_W      = CNT_W - 1;
  localparam int unsigned WIN_W       = 5;
  localparam int unsigned PASS_W      = 10;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(11);
  localparam logic [PASS_W-1:0] LIMIT_RESET  = PASS_W'(1023);

  // Register index, taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  // Input action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_WIN,
    S_CAND,
    S_CANDW,
    S_SCAN,
    S_DECIDE,
    S_COPY,
    S_CPEND,
    S_PASSEND
  } state_e;

  typedef struct packed {
    logic load;  // take a new candidate, clear the counts
    logic en;    // compare one window sample against the candidate
  } rank_ctl_t;

endpackage

[sv/rmf_ram.sv]
// ----------------------------------------------------------------------------
// rmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rmf_rank_unit.sv]
// ----------------------------------------------------------------------------
// rmf_rank_unit: shared compare unit for median selection
// Holds one candidate and counts window samples below and not above it.
// ----------------------------------------------------------------------------
module rmf_rank_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rmf_pkg::rank_ctl_t                    ctl_i,
  input  logic signed [rmf_pkg::SAMPLE_BITS-1:0] data_i,
  input  logic [rmf_pkg::HALF_W-1:0]            mid_i,
  output logic signed [rmf_pkg::SAMPLE_BITS-1:0] cand_o,
  output logic                                  found_o
);
  import rmf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] cand_q;
  logic [CNT_W-1:0] less_q, less_d, leq_q, leq_d;
  logic             lt, eq;

  assign lt = data_i < cand_q;
  assign eq = data_i == cand_q;

  always_comb begin
    less_d = less_q;
    leq_d  = leq_q;
    if (ctl_i.load) begin
      less_d = '0;
      leq_d  = '0;
    end else if (ctl_i.en) begin
      less_d = less_q + CNT_W'(lt);
      leq_d  = leq_q + CNT_W'(lt | eq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= '0;
      leq_q  <= '0;
    end else begin
      less_q <= less_d;
      leq_q  <= leq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cand_q <= data_i;
    end
  end

  // Candidate holds the middle rank: at most mid below it, over mid not above
  assign found_o = (less_q <= CNT_W'(mid_i)) && (CNT_W'(mid_i) < leq_q);
  assign cand_o  = cand_q;

endmodule

[sv/recursive_median_filter_unit.sv]
// ----------------------------------------------------------------------------
// recursive_median_filter_unit: running median iterated to its root
// Loads a segment, filters it pass after pass, and reads samples back.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. A load
//   (action 0) writes one sample and gives no result, unless last_sample
//   is set: then the filter runs over the whole segment and one status
//   result (is_status 1) reports passes run and convergence. A read
//   (action 1) returns the sample at read_index, read from the registered
//   memory into the result register; indices past the segment return zero.
//   Each pass works sample by sample through one shared compare unit: for
//   each output sample the candidates of the clipped window w are tried in
//   order and each scans the window once, then a copy sweep writes the pass
//   back. Passes repeat until one changes nothing or pass_limit passes have
//   run; a pass_limit of zero runs a single pass.
//   Results show for one cycle on result_valid_o; the receiver cannot stall.
//   Reset clears segment length, pass count and flags; the sample memories
//   are not cleared and only entries below the segment length are read.
//   The user writes configuration (window_length at 0x0, pass_limit at 0x4)
//   through the APB port only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module recursive_median_filter_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   action_i,
  input  logic signed [rmf_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic                                   last_sample_i,
  input  logic [rmf_pkg::ADDR_W-1:0]             read_index_i,
  output logic                                   result_valid_o,
  output logic signed [rmf_pkg::SAMPLE_BITS-1:0] filtered_value_o,
  output logic [rmf_pkg::PASS_W-1:0]             passes_run_o,
  output logic                                   converged_o,
  output logic                                   is_status_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rmf_pkg::PADDR_W-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import rmf_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic [WIN_W-1:0]  win_q;
  logic [PASS_W-1:0] lim_q;
  logic              cfg_we;

  // Segment and pass control
  logic [LEN_W-1:0]  seg_q, seg_d;
  logic [PASS_W-1:0] pc_q, pc_d;
  logic              chg_q, chg_d;
  logic              closed_q, closed_d;
  logic [HALF_W-1:0] h_q, h_d;
  logic [PASS_W-1:0] plim_q, plim_d;

  // Window walk
  logic [ADDR_W-1:0] i_q, i_d, b_q, b_d, e_q, e_d, cj_q, cj_d, k_q, k_d, c_q, c_d;
  logic [HALF_W-1:0] m_q, m_d;
  logic              cpv_q, cpv_d;
  logic [ADDR_W-1:0] cpa_q, cpa_d;
  logic              inr_q, inr_d;

  // Result register
  logic                          rv_q, rv_d, cv_q, cv_d, st_q, st_d;
  logic signed [SAMPLE_BITS-1:0] fv_q, fv_d;
  logic [PASS_W-1:0]             pr_q, pr_d;

  // Memories
  logic                          s_we, p_we;
  logic [ADDR_W-1:0]             s_waddr, s_raddr, p_raddr;
  logic signed [SAMPLE_BITS-1:0] s_wdata, s_rdata, p_rdata;

  rank_ctl_t                     rctl;
  logic signed [SAMPLE_BITS-1:0] cand;
  logic                          found;

  logic accept, last_i, last_c, stop;
  logic [LEN_W-1:0] nm1;
  logic [LEN_W:0]   lo_w, hi_w, len_w;
  logic [LEN_W-1:0] wb, we_idx;
  logic [LEN_W-1:0] seg_base;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  assign nm1    = seg_q - LEN_W'(1);
  assign last_i = ({1'b0, i_q} == nm1);
  assign last_c = ({1'b0, c_q} == nm1);
  assign stop   = !chg_q || (pc_q >= plim_q);

  // Clip the window at both ends, then widen an even window to odd
  always_comb begin
    lo_w = ({2'b0, i_q} >= (LEN_W+1)'(h_q)) ? ({2'b0, i_q} - (LEN_W+1)'(h_q)) : '0;
    hi_w = {2'b0, i_q} + (LEN_W+1)'(h_q);
    if (hi_w > {1'b0, nm1}) begin
      hi_w = {1'b0, nm1};
    end
    wb     = lo_w[LEN_W-1:0];
    we_idx = hi_w[LEN_W-1:0];
    len_w  = hi_w - lo_w + (LEN_W+1)'(1);
    if (!len_w[0]) begin
      if (we_idx < nm1) begin
        we_idx = we_idx + LEN_W'(1);
      end else if (wb != '0) begin
        wb = wb - LEN_W'(1);
      end
    end
    len_w = {1'b0, we_idx} - {1'b0, wb};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_READ) begin
            state_d = S_READ;
          end else if (last_sample_i) begin
            state_d = S_WIN;
          end
        end
      end
      S_READ:   state_d = S_IDLE;
      S_WIN:    state_d = S_CAND;
      S_CAND:   state_d = S_CANDW;
      S_CANDW:  state_d = S_SCAN;
      S_SCAN:   state_d = (k_q == e_q) ? S_DECIDE : S_SCAN;
      S_DECIDE: begin
        if (!found) begin
          state_d = S_CAND;
        end else begin
          state_d = last_i ? S_COPY : S_WIN;
        end
      end
      S_COPY:    state_d = last_c ? S_CPEND : S_COPY;
      S_CPEND:   state_d = S_PASSEND;
      S_PASSEND: state_d = stop ? S_IDLE : S_WIN;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    seg_d = seg_q;   pc_d = pc_q;     chg_d = chg_q;   closed_d = closed_q;
    h_d = h_q;       plim_d = plim_q; i_d = i_q;       b_d = b_q;
    e_d = e_q;       cj_d = cj_q;     k_d = k_q;       c_d = c_q;
    m_d = m_q;       inr_d = inr_q;
    cpv_d = (state_q == S_COPY);
    cpa_d = c_q;
    rv_d = 1'b0;     fv_d = fv_q;     pr_d = pr_q;     cv_d = cv_q;  st_d = st_q;
    s_we = 1'b0;     s_waddr = cpa_q; s_wdata = p_rdata;
    s_raddr = read_index_i;
    p_we = 1'b0;     p_raddr = c_q;
    rctl = '0;
    seg_base = seg_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_READ) begin
            inr_d = ({1'b0, read_index_i} < seg_q);
          end else begin
            // A load after filtering opens a new segment
            if (closed_q) begin
              seg_base = '0;
              pc_d     = '0;
              chg_d    = 1'b0;
              closed_d = 1'b0;
            end
            s_waddr = seg_base[ADDR_W-1:0];
            s_wdata = sample_value_i;
            if (seg_base < LEN_W'(MAX_SAMPLES)) begin
              s_we  = 1'b1;
              seg_d = seg_base + LEN_W'(1);
            end else begin
              seg_d = seg_base;
            end
            if (last_sample_i) begin
              i_d    = '0;
              pc_d   = '0;
              chg_d  = 1'b0;
              h_d    = HALF_W'((win_q | WIN_W'(1)) >> 1);
              plim_d = (lim_q == '0) ? PASS_W'(1) : lim_q;
            end
          end
        end
      end
      S_READ: begin
        rv_d = 1'b1;
        fv_d = inr_q ? s_rdata : '0;
        pr_d = closed_q ? pc_q : '0;
        cv_d = closed_q && !chg_q;
        st_d = 1'b0;
      end
      S_WIN: begin
        b_d  = wb[ADDR_W-1:0];
        e_d  = we_idx[ADDR_W-1:0];
        cj_d = wb[ADDR_W-1:0];
        m_d  = HALF_W'(len_w >> 1);
      end
      S_CAND: begin
        s_raddr = cj_q;
      end
      S_CANDW: begin
        rctl.load = 1'b1;
        s_raddr   = b_q;
        k_d       = b_q;
      end
      S_SCAN: begin
        rctl.en = 1'b1;
        s_raddr = k_q + ADDR_W'(1);
        k_d     = k_q + ADDR_W'(1);
      end
      S_DECIDE: begin
        if (found) begin
          p_we = 1'b1;
          i_d  = i_q + ADDR_W'(1);
          c_d  = '0;
        end else begin
          cj_d = cj_q + ADDR_W'(1);
        end
      end
      S_COPY: begin
        s_raddr = c_q;
        c_d     = c_q + ADDR_W'(1);
      end
      S_CPEND: begin
        pc_d = pc_q + PASS_W'(1);
      end
      S_PASSEND: begin
        if (stop) begin
          closed_d = 1'b1;
          rv_d     = 1'b1;
          fv_d     = '0;
          pr_d     = pc_q;
          cv_d     = !chg_q;
          st_d     = 1'b1;
        end else begin
          i_d   = '0;
          chg_d = 1'b0;
        end
      end
      default: ;
    endcase

    // Write back one pass sample per cycle, in the cycle after its read
    if (cpv_q) begin
      s_we    = 1'b1;
      s_waddr = cpa_q;
      s_wdata = p_rdata;
      if (p_rdata != s_rdata) begin
        chg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      win_q    <= WINDOW_RESET;
      lim_q    <= LIMIT_RESET;
      seg_q    <= '0;
      pc_q     <= '0;
      chg_q    <= 1'b0;
      closed_q <= 1'b0;
      cpv_q    <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      seg_q    <= seg_d;
      pc_q     <= pc_d;
      chg_q    <= chg_d;
      closed_q <= closed_d;
      cpv_q    <= cpv_d;
      rv_q     <= rv_d;
      if (cfg_we) begin
        if (paddr[2] == REG_WINDOW) begin
          win_q <= pwdata[WIN_W-1:0];
        end else begin
          lim_q <= pwdata[PASS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    plim_q <= plim_d;
    i_q    <= i_d;
    b_q    <= b_d;
    e_q    <= e_d;
    cj_q   <= cj_d;
    k_q    <= k_d;
    c_q    <= c_d;
    m_q    <= m_d;
    cpa_q  <= cpa_d;
    inr_q  <= inr_d;
    fv_q   <= fv_d;
    pr_q   <= pr_d;
    cv_q   <= cv_d;
    st_q   <= st_d;
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW: prdata = {{(32-WIN_W){1'b0}}, win_q};
      REG_LIMIT:  prdata = {{(32-PASS_W){1'b0}}, lim_q};
      default:    prdata = '0;
    endcase
  end

  rmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  rmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_pass_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (i_q),
    .wdata_i (cand),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  rmf_rank_unit u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rctl),
    .data_i  (s_rdata),
    .mid_i   (m_q),
    .cand_o  (cand),
    .found_o (found)
  );

  assign result_valid_o   = rv_q;
  assign filtered_value_o = fv_q;
  assign passes_run_o     = pr_q;
  assign converged_o      = cv_q;
  assign is_status_o      = st_q;

`ifndef SYNTHESIS
  a_status_has_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_status_o) |-> (passes_run_o != '0 && filtered_value_o == '0))
    else $error("status result without a pass");

  a_cand_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAND) |-> (cj_q >= b_q && cj_q <= e_q))
    else $error("candidate left the window");

  a_mid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAND) |-> (ADDR_W'(m_q) <= (e_q - b_q)))
    else $error("middle rank beyond window");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN) |-> (pc_q < plim_q))
    else $error("pass started past the limit");
`endif

endmodule

[test/recursive_median_filter_unit_tb.sv]
// ----------------------------------------------------------------------------
// recursive_median_filter_unit_tb: self-checking bench for the median filter
// Drives loads and reads through the start/busy port and rewrites the window
// and pass limit between segments. A local model filters each segment to its
// root, and a scoreboard compares every result strobe, field by field.
// ----------------------------------------------------------------------------
module recursive_median_filter_unit_tb;
  import rmf_pkg::*;

  localparam int STOP_CYCLES = 50000000;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [PASS_W-1:0]             passes;
    logic                          conv;
    logic                          status;
  } filter_result_t;

  // Expected results in arrival order; counts every failure seen.
  class filter_scoreboard;
    filter_result_t pending_q[$];
    int             errors;

    function void note(filter_result_t r);
      pending_q.push_back(r);
    endfunction

    function void check(filter_result_t got);
      filter_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result value=%0d status=%0b", got.value, got.status);
        return;
      end
      want = pending_q.pop_front();
      if (got.value !== want.value || got.passes !== want.passes ||
          got.conv !== want.conv || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp value=%0d passes=%0d conv=%0b stat=%0b / got %0d %0d %0b %0b",
                   want.value, want.passes, want.conv, want.status,
                   got.value, got.passes, got.conv, got.status);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    action_i = ACT_LOAD;
  logic signed [31:0]      sample_value_i = '0;
  logic                    last_sample_i = 1'b0;
  logic [ADDR_W-1:0]       read_index_i = '0;
  logic                    result_valid_o;
  logic signed [31:0]      filtered_value_o;
  logic [PASS_W-1:0]       passes_run_o;
  logic                    converged_o;
  logic                    is_status_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  recursive_median_filter_unit uut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .sample_value_i, .last_sample_i,
    .read_index_i, .result_valid_o, .filtered_value_o, .passes_run_o,
    .converged_o, .is_status_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  filter_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;

  // Shadow of the block: segment memory, counters and registers.
  int          seg_mem [MAX_SAMPLES];
  int          next_mem[MAX_SAMPLES];
  int          seg_len;
  logic [9:0]  pass_cnt;
  logic        changed;
  logic        closed;
  logic [4:0]  win_reg;
  logic [9:0]  limit_reg;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > STOP_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample each strobed result at the edge that ends its cycle.
  always @(posedge clk_i) begin
    filter_result_t got;
    if (rst_ni && result_valid_o) begin
      got.value  = filtered_value_o;
      got.passes = passes_run_o;
      got.conv   = converged_o;
      got.status = is_status_o;
      sb.check(got);
    end
  end

  // Median of seg_mem[lo..hi], lower middle on an even count.
  function automatic int window_median(int lo, int hi);
    int vals[MAX_WINDOW + 1];
    int cnt;
    int k;
    int v;
    cnt = 0;
    for (int j = lo; j <= hi && cnt < MAX_WINDOW + 1; j++) begin
      v = seg_mem[j];
      k = cnt;
      while (k > 0 && vals[k-1] > v) begin
        vals[k] = vals[k-1];
        k--;
      end
      vals[k] = v;
      cnt++;
    end
    if (cnt == 0) return 0;
    return vals[(cnt - 1) / 2];
  endfunction

  // Run passes until the segment stops changing or the limit is hit.
  function automatic void filter_to_root();
    int span;
    int half;
    int lim;
    int b;
    int e;
    span = win_reg;
    if (span % 2 == 0) span++;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    half = (span - 1) / 2;
    lim = (limit_reg == 0) ? 1 : limit_reg;
    pass_cnt = 0;
    changed = 0;
    if (seg_len <= 0) return;
    do begin
      changed = 0;
      for (int i = 0; i < seg_len; i++) begin
        b = (i - half < 0) ? 0 : i - half;
        e = (i + half > seg_len - 1) ? seg_len - 1 : i + half;
        if (((e - b + 1) % 2) == 0) begin
          e++;
          if (e > seg_len - 1) begin
            e--;
            if (b > 0) b--;
          end
        end
        next_mem[i] = window_median(b, e);
      end
      for (int i = 0; i < seg_len; i++) begin
        if (next_mem[i] != seg_mem[i]) changed = 1;
        seg_mem[i] = next_mem[i];
      end
      pass_cnt = pass_cnt + 10'd1;
    end while (changed && pass_cnt < lim);
  endfunction

  // Update the shadow for one accepted transaction; note any result.
  function automatic void predict_item(logic act, logic [31:0] val, logic last,
                                       logic [ADDR_W-1:0] idx);
    filter_result_t r;
    if (act == ACT_LOAD) begin
      if (closed) begin
        seg_len = 0;
        pass_cnt = 0;
        changed = 0;
        closed = 0;
      end
      if (seg_len < MAX_SAMPLES) begin
        seg_mem[seg_len] = int'(val);
        seg_len++;
      end
      if (!last) return;
      filter_to_root();
      closed = 1;
      r.value = 0;
      r.passes = pass_cnt;
      r.conv = !changed;
      r.status = 1;
      sb.note(r);
      return;
    end
    r.value = (idx < seg_len) ? seg_mem[idx] : 0;
    r.passes = closed ? pass_cnt : '0;
    r.conv = closed && !changed;
    r.status = 0;
    sb.note(r);
  endfunction

  // Present one transaction, hold until taken, then maybe open a gap.
  task automatic send_item(logic act, logic [31:0] val, logic last, logic [ADDR_W-1:0] idx);
    start          <= 1'b1;
    action_i       <= act;
    sample_value_i <= val;
    last_sample_i  <= last;
    read_index_i   <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(act, val, last, idx);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  // Drop start and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Two-phase register write; the caller has drained the block.
  task automatic write_reg(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW) win_reg = val[4:0];
    else limit_reg = val[9:0];
    @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] win, logic [31:0] lim);
    drain();
    write_reg(REG_WINDOW, win);
    write_reg(REG_LIMIT, lim);
  endtask

  // Load one segment; values come from a narrow or a full range.
  task automatic load_segment(int n, bit narrow);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      v = narrow ? 32'($signed($urandom_range(0, 8)) - 4) : $urandom();
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_item(ACT_LOAD, v, i == n - 1, ADDR_W'($urandom()));
    end
  endtask

  task automatic read_some(int count, int n);
    logic [ADDR_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0:       idx = ADDR_W'($urandom());
        1:       idx = ADDR_W'(n);
        default: idx = ADDR_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
      endcase
      send_item(ACT_READ, $urandom(), $urandom_range(0, 1), idx);
    end
  endtask

  initial begin
    int n;
    int w;
    seg_len = 0;
    pass_cnt = 0;
    changed = 0;
    closed = 0;
    win_reg = WINDOW_RESET;
    limit_reg = LIMIT_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reads of an empty segment, then the reset window.
    send_item(ACT_READ, 32'hffff_ffff, 1'b1, '0);
    send_item(ACT_READ, '0, 1'b0, '1);
    send_item(ACT_LOAD, 32'h8000_0000, 1'b1, '0);
    send_item(ACT_READ, '0, 1'b0, '0);
    // Extremes, then an even-length segment shorter than the window.
    send_item(ACT_LOAD, 32'h7fff_ffff, 1'b0, '0);
    send_item(ACT_LOAD, 32'h8000_0000, 1'b0, '0);
    send_item(ACT_READ, '0, 1'b0, 12'd1);  // raw sample before filtering
    send_item(ACT_LOAD, 32'hffff_ffff, 1'b0, '0);
    send_item(ACT_LOAD, 32'h0000_0001, 1'b1, '0);
    read_some(4, 4);
    // Even window, one pass only.
    configure(32'd4, 32'd1);
    load_segment(9, 1'b0);
    read_some(3, 9);
    configure(32'd0, 32'd0);
    load_segment(3, 1'b0);
    configure(32'd31, 32'd1023);
    load_segment(8, 1'b1);
    read_some(2, 8);

    // Random segments with reads in between; settle at every setting change.
    while (items_sent < 1100) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       w = 31;
          1:       w = $urandom_range(0, 2);
          default: w = $urandom_range(0, 31);
        endcase
        configure(w, $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 6));
      end
      n = $urandom_range(1, (win_reg > 13) ? 12 : 24);
      if ($urandom_range(0, 9) == 0 && win_reg < 6) n = $urandom_range(60, 120);
      if ($urandom_range(0, 3) == 0) begin
        load_segment(n / 2 + 1, $urandom_range(0, 1));
        read_some(2, 0);
        n = n - n / 2;
      end
      load_segment(n, $urandom_range(0, 2) != 0);
      read_some($urandom_range(1, 8), seg_len);
    end
    send_item(ACT_READ, '0, 1'b0, '1);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
